[design/wildcard_glob_matcher_defines.svh]
// Assertion macros for the wildcard glob matcher.
`ifndef WILDCARD_GLOB_MATCHER_DEFINES_SVH
`define WILDCARD_GLOB_MATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WGM_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wgm: %m check failed");

// Next-cycle implication, checked out of reset.
`define WGM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wgm: %m check failed");

`endif

[design/wgm_pkg.sv]
// Shared types, constants and helpers for the wildcard glob matcher.
`default_nettype none

package wgm_pkg;

    localparam int MASK_LEN_DEF  = 16;
    localparam int CHAR_W        = 8;
    localparam int MASK_LENGTH_W = 5;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CHAR_W-1:0] STAR_CHAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] QUESTION_CHAR = 8'h3F;
    localparam logic [CHAR_W-1:0] UPPER_A       = 8'h41;
    localparam logic [CHAR_W-1:0] UPPER_Z       = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

    typedef enum logic [1:0] {
        REG_MASK_LOW    = 2'd0,
        REG_MASK_HIGH   = 2'd1,
        REG_MASK_LENGTH = 2'd2,
        REG_CASE_FOLD   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic rearm;      // set in the cycle after any register write
        logic case_fold;
    } t_cfg_ctl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_flags;

    // ASCII upper case to lower case when folding is enabled.
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c,
                                                    input logic en);
        logic is_upper;
        is_upper = (c >= UPPER_A) && (c <= UPPER_Z);
        return (en && is_upper) ? (c + CASE_OFFSET) : c;
    endfunction

endpackage

`default_nettype wire

[design/wgm_cfg.sv]
// Configuration registers, APB access and derived mask vectors.
`default_nettype none

module wgm_cfg #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wgm_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [wgm_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [wgm_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output wgm_pkg::t_cfg_ctl                     o_ctl,
    output logic [MASK_LEN*wgm_pkg::CHAR_W-1:0]   o_chars,   // folded mask characters
    output logic [MASK_LEN-1:0]                   o_lit,     // literal compare enabled
    output logic [MASK_LEN-1:0]                   o_any,     // '?' in use
    output logic [MASK_LEN-1:0]                   o_star,    // '*' in use
    output logic [MASK_LEN:0]                     o_accept   // one-hot final position
);
    import wgm_pkg::*;

    localparam int LEN_W = $clog2(MASK_LEN + 1);

    logic [APB_DATA_W-1:0]    r_mask_low,    n_mask_low;
    logic [APB_DATA_W-1:0]    r_mask_high,   n_mask_high;
    logic [MASK_LENGTH_W-1:0] r_mask_length, n_mask_length;
    logic                     r_case_fold,   n_case_fold;
    logic                     r_rearm;
    logic                     wr;
    t_reg_idx                 idx;
    logic [LEN_W-1:0]         len_eff;
    logic [MASK_LEN-1:0]      len_mask;

    assign wr     = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[4:3]);
    assign pready = 1'b1;

    always_comb begin
        n_mask_low    = r_mask_low;
        n_mask_high   = r_mask_high;
        n_mask_length = r_mask_length;
        n_case_fold   = r_case_fold;
        if (wr) begin
            unique case (idx)
                REG_MASK_LOW:    n_mask_low    = pwdata;
                REG_MASK_HIGH:   n_mask_high   = pwdata;
                REG_MASK_LENGTH: n_mask_length = pwdata[MASK_LENGTH_W-1:0];
                REG_CASE_FOLD:   n_case_fold   = pwdata[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_low    <= '0;
            r_mask_high   <= '0;
            r_mask_length <= '0;
            r_case_fold   <= 1'b0;
            r_rearm       <= 1'b0;
        end else begin
            r_mask_low    <= n_mask_low;
            r_mask_high   <= n_mask_high;
            r_mask_length <= n_mask_length;
            r_case_fold   <= n_case_fold;
            r_rearm       <= wr;
        end
    end

    always_comb begin
        unique case (idx)
            REG_MASK_LOW:    prdata = r_mask_low;
            REG_MASK_HIGH:   prdata = r_mask_high;
            REG_MASK_LENGTH: prdata = APB_DATA_W'(r_mask_length);
            REG_CASE_FOLD:   prdata = APB_DATA_W'(r_case_fold);
        endcase
    end

    assign o_ctl.rearm     = r_rearm;
    assign o_ctl.case_fold = r_case_fold;

    // Lengths past the mask capacity clamp to the capacity.
    assign len_eff = (r_mask_length > MASK_LENGTH_W'(MASK_LEN)) ? LEN_W'(MASK_LEN)
                                                                : r_mask_length[LEN_W-1:0];

    for (genvar g = 0; g < MASK_LEN; g++) begin : g_pos
        logic [CHAR_W-1:0] raw;
        if (g < 8) begin : g_low
            assign raw = r_mask_low[CHAR_W*g +: CHAR_W];
        end else begin : g_high
            assign raw = r_mask_high[CHAR_W*(g-8) +: CHAR_W];
        end
        assign len_mask[g]                   = LEN_W'(g) < len_eff;
        assign o_chars[CHAR_W*g +: CHAR_W]   = fold_char(raw, r_case_fold);
        assign o_star[g]                     = len_mask[g] && (raw == STAR_CHAR);
        assign o_any[g]                      = len_mask[g] && (raw == QUESTION_CHAR);
        assign o_lit[g]                      = len_mask[g] && (raw != STAR_CHAR);
    end

    for (genvar g = 0; g <= MASK_LEN; g++) begin : g_acc
        assign o_accept[g] = (len_eff == LEN_W'(g));
    end

endmodule

`default_nettype wire

[design/wgm_front.sv]
// Front end: takes input transactions and classifies each byte against the mask.
`default_nettype none

module wgm_front #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                             i_valid,
    output logic                                  o_stall,
    input  wire logic [wgm_pkg::CHAR_W-1:0]       i_char_value,
    input  wire logic                             i_end_of_string,
    input  wire logic                             i_cfg_busy,
    input  wire wgm_pkg::t_cfg_ctl                i_ctl,
    input  wire logic [MASK_LEN*wgm_pkg::CHAR_W-1:0] i_chars,
    input  wire logic [MASK_LEN-1:0]              i_lit,
    input  wire logic [MASK_LEN-1:0]              i_any,
    input  wire wgm_pkg::t_q_flags                i_q_flags,
    output logic                                  o_push,
    output logic [MASK_LEN:0]                     o_entry   // {end_of_string, hit vector}
);
    import wgm_pkg::*;

    logic [CHAR_W-1:0]   c_fold;
    logic [MASK_LEN-1:0] hit;

    // Hold off input while the queue is full, during a register access and in the rearm cycle after a write.
    assign o_stall = i_q_flags.full || i_cfg_busy || i_ctl.rearm;
    assign o_push  = i_valid && !o_stall;

    assign c_fold = fold_char(i_char_value, i_ctl.case_fold);

    always_comb begin
        for (int i = 0; i < MASK_LEN; i++) begin
            hit[i] = i_any[i] || (i_lit[i] && (i_chars[CHAR_W*i +: CHAR_W] == c_fold));
        end
    end

    assign o_entry = {i_end_of_string, hit};

endmodule

`default_nettype wire

[design/wgm_queue.sv]
// Short FIFO between the front end and the back end.
`default_nettype none

module wgm_queue #(
    parameter int W = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic [W-1:0]  i_wr_data,
    input  wire logic          i_pop,
    output logic      [W-1:0]  o_rd_data,
    output wgm_pkg::t_q_flags  o_flags
);
    import wgm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data     = r_mem[r_rd_ptr];
    assign o_flags.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

`default_nettype wire

[design/wgm_back.sv]
// Back end: NFA live-position update and result register.
`default_nettype none

module wgm_back #(
    parameter int MASK_LEN = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [MASK_LEN:0]    i_entry,
    input  wire wgm_pkg::t_q_flags    i_q_flags,
    output logic                      o_pop,
    input  wire wgm_pkg::t_cfg_ctl    i_ctl,
    input  wire logic [MASK_LEN-1:0]  i_star,
    input  wire logic [MASK_LEN:0]    i_accept,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_matched
);
    import wgm_pkg::*;

    localparam int LIVE_W = MASK_LEN + 1;

    logic [LIVE_W-1:0]   r_live, n_live;
    logic                r_out_valid, n_out_valid;
    logic                r_matched, n_matched;
    logic                eos;
    logic [MASK_LEN-1:0] hit;
    logic [LIVE_W-1:0]   start_set;
    logic [LIVE_W-1:0]   step_set;

    // Star closure: a carry runs up each run of stars from any live star
    // position and lands on the first position past the run.
    function automatic logic [LIVE_W-1:0] closure(input logic [LIVE_W-1:0] x,
                                                  input logic [MASK_LEN-1:0] star);
        logic [LIVE_W-1:0] s;
        s = {1'b0, star};
        return x | ((s + (x & s)) ^ s);
    endfunction

    assign eos = i_entry[MASK_LEN];
    assign hit = i_entry[MASK_LEN-1:0];

    assign start_set = closure(LIVE_W'(1), i_star);
    // Star keeps its position; a hit advances by one.
    assign step_set  = closure({1'b0, r_live[MASK_LEN-1:0] & i_star}
                             | {r_live[MASK_LEN-1:0] & hit, 1'b0}, i_star);

    assign o_pop = !i_q_flags.empty && (!eos || !r_out_valid || !i_stall);

    always_comb begin
        n_live      = r_live;
        n_out_valid = r_out_valid;
        n_matched   = r_matched;
        priority if (i_ctl.rearm) begin
            n_live = start_set;
        end else if (o_pop) begin
            n_live = eos ? start_set : step_set;
        end
        if (o_pop && eos) begin
            n_out_valid = 1'b1;
            n_matched   = |(r_live & i_accept);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live      <= LIVE_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
    end

    assign o_valid   = r_out_valid;
    assign o_matched = r_matched;

endmodule

`default_nettype wire

[design/wildcard_glob_matcher.sv]
// Top level of the wildcard glob matcher: register port, front end, queue, back end.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_char_value, i_end_of_string
//   result    out        o_valid / i_stall    o_matched
//   config    in         APB psel/penable     paddr, pwdata -> prdata
//
// One byte per cycle sustained while o_stall is low. A byte is classified against
// all mask positions in the front end the cycle it is taken, queued, and the back
// end folds it into the live-position set on the next pop: one 17-bit star-closure
// add. An end-of-string result passes through the queue and the result register.
// A stalled result holds the back end only when the next entry is itself an
// end of string; bytes keep flowing until the two-entry queue fills.
// Synchronous reset; input held off during APB access and the rearm after a write.
`default_nettype none

`include "wildcard_glob_matcher_defines.svh"

module wildcard_glob_matcher #(
    parameter int MASK_LEN = wgm_pkg::MASK_LEN_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // byte stream
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [wgm_pkg::CHAR_W-1:0]      i_char_value,
    input  wire logic                            i_end_of_string,
    // match result
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_matched,
    // register port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wgm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [wgm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [wgm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);
    import wgm_pkg::*;

    t_cfg_ctl                     ctl;
    logic [MASK_LEN*CHAR_W-1:0]   chars;
    logic [MASK_LEN-1:0]          lit;
    logic [MASK_LEN-1:0]          any;
    logic [MASK_LEN-1:0]          star;
    logic [MASK_LEN:0]            accept;
    t_q_flags                     q_flags;
    logic                         q_push;
    logic                         q_pop;
    logic [MASK_LEN:0]            q_wr_entry;
    logic [MASK_LEN:0]            q_rd_entry;

    // Registers: mask bytes, length, case fold; derived per-position vectors.
    wgm_cfg #(
        .MASK_LEN (MASK_LEN)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_ctl    (ctl),
        .o_chars  (chars),
        .o_lit    (lit),
        .o_any    (any),
        .o_star   (star),
        .o_accept (accept)
    );

    // Front end: each byte becomes a hit vector over mask positions.
    wgm_front #(
        .MASK_LEN (MASK_LEN)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_value    (i_char_value),
        .i_end_of_string (i_end_of_string),
        .i_cfg_busy      (psel),
        .i_ctl           (ctl),
        .i_chars         (chars),
        .i_lit           (lit),
        .i_any           (any),
        .i_q_flags       (q_flags),
        .o_push          (q_push),
        .o_entry         (q_wr_entry)
    );

    wgm_queue #(
        .W (MASK_LEN + 1)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (q_push),
        .i_wr_data (q_wr_entry),
        .i_pop     (q_pop),
        .o_rd_data (q_rd_entry),
        .o_flags   (q_flags)
    );

    // Back end: live set update; end of string reports and rearms.
    wgm_back #(
        .MASK_LEN (MASK_LEN)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (q_rd_entry),
        .i_q_flags (q_flags),
        .o_pop     (q_pop),
        .i_ctl     (ctl),
        .i_star    (star),
        .i_accept  (accept),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_matched (o_matched)
    );

    // Queue never written while full nor read while empty.
    `WGM_ASSERT_IMPL(a_no_overflow, q_push, !q_flags.full)
    `WGM_ASSERT_IMPL(a_no_underflow, q_pop, !q_flags.empty)
    // An end-of-string entry leaving the queue always yields a result.
    `WGM_ASSERT_NEXT(a_eos_gives_result, q_pop && q_rd_entry[MASK_LEN], o_valid)
    // No byte taken while a register access or rearm is under way.
    `WGM_ASSERT_IMPL(a_no_accept_in_cfg, i_valid && !o_stall, !psel && !ctl.rearm)

endmodule

`default_nettype wire
